### sv/stpb_pkg.sv
// Shared types, register codes and fixed-point helpers for the subpixel text blend.
// No dependencies; every other file of the block uses it by scoped names.
package stpb_pkg;

	localparam int unsigned ChanW      = 8;
	localparam int unsigned TableDepth = 256;
	localparam int unsigned TableAddrW = $clog2(TableDepth);
	localparam int unsigned Lanes      = 3;
	localparam int unsigned CfgAddrW   = 5;
	localparam int unsigned CfgDataW   = 32;
	localparam int unsigned InDataW    = 72;
	localparam int unsigned OutDataW   = 32;

	typedef enum logic [2:0] {
		REG_TEXT_RED      = 3'd0,
		REG_TEXT_GREEN    = 3'd1,
		REG_TEXT_BLUE     = 3'd2,
		REG_TEXT_ALPHA    = 3'd3,
		REG_BGR_ORDER     = 3'd4,
		REG_SUBPIXEL_MODE = 3'd5
	} reg_idx_t;

	typedef enum logic {
		KIND_BLEND     = 1'b0,
		KIND_TABLE_WR  = 1'b1
	} kind_t;

	typedef struct packed {
		logic [ChanW-1:0] red;
		logic [ChanW-1:0] green;
		logic [ChanW-1:0] blue;
		logic [ChanW-1:0] alpha;
		logic             bgr;
		logic             mode;
	} cfg_t;

	typedef struct packed {
		logic                  en;
		logic [TableAddrW-1:0] addr;
		logic [ChanW-1:0]      data;
	} tbl_wr_t;

	// floor(x / 255), exact for x below 65535
	function automatic logic [8:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
		return t[16:8];
	endfunction

	function automatic logic [7:0] clamp255(input logic [8:0] v);
		return v[8] ? 8'hFF : v[7:0];
	endfunction

	// floor(s / 3) for s up to 765
	function automatic logic [7:0] div3(input logic [9:0] s);
		logic [19:0] p;
		p = {10'd0, s} * 20'd683;
		return p[18:11];
	endfunction

endpackage

### sv/stpb_cfg_regs.sv
// APB register file for text colour, text alpha, panel order and coverage mode.
// Depends on stpb_pkg for the register codes and the cfg_t bundle.
module stpb_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [stpb_pkg::CfgAddrW-1:0]      paddr,
	input  logic [stpb_pkg::CfgDataW-1:0]      pwdata,
	output logic [stpb_pkg::CfgDataW-1:0]      prdata,
	output stpb_pkg::cfg_t                     cfg
);

	stpb_pkg::cfg_t   cfg_q;
	stpb_pkg::reg_idx_t idx;
	logic             wr;

	assign idx = stpb_pkg::reg_idx_t'(paddr[4:2]);
	assign wr  = psel & penable & pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.red   <= '0;
			cfg_q.green <= '0;
			cfg_q.blue  <= '0;
			cfg_q.alpha <= 8'hFF;
			cfg_q.bgr   <= 1'b0;
			cfg_q.mode  <= 1'b0;
		end else if (wr) begin
			unique case (idx)
				stpb_pkg::REG_TEXT_RED:      cfg_q.red   <= pwdata[7:0];
				stpb_pkg::REG_TEXT_GREEN:    cfg_q.green <= pwdata[7:0];
				stpb_pkg::REG_TEXT_BLUE:     cfg_q.blue  <= pwdata[7:0];
				stpb_pkg::REG_TEXT_ALPHA:    cfg_q.alpha <= pwdata[7:0];
				stpb_pkg::REG_BGR_ORDER:     cfg_q.bgr   <= pwdata[0];
				stpb_pkg::REG_SUBPIXEL_MODE: cfg_q.mode  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			stpb_pkg::REG_TEXT_RED:      prdata[7:0] = cfg_q.red;
			stpb_pkg::REG_TEXT_GREEN:    prdata[7:0] = cfg_q.green;
			stpb_pkg::REG_TEXT_BLUE:     prdata[7:0] = cfg_q.blue;
			stpb_pkg::REG_TEXT_ALPHA:    prdata[7:0] = cfg_q.alpha;
			stpb_pkg::REG_BGR_ORDER:     prdata[0]   = cfg_q.bgr;
			stpb_pkg::REG_SUBPIXEL_MODE: prdata[0]   = cfg_q.mode;
			default:                     prdata      = '0;
		endcase
	end

endmodule

### sv/stpb_gamma_mem.sv
// Gamma table storage: two copies written together, one read at two addresses,
// one at a third, with registered read data and per-entry valid bits. Uses stpb_pkg.
module stpb_gamma_mem (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  stpb_pkg::tbl_wr_t                               wr,
	input  logic                                            rd_en,
	input  logic [stpb_pkg::Lanes-1:0][stpb_pkg::TableAddrW-1:0] rd_addr,
	output logic [stpb_pkg::Lanes-1:0][stpb_pkg::ChanW-1:0] rd_data
);

	logic [stpb_pkg::ChanW-1:0] mem_a [stpb_pkg::TableDepth];
	logic [stpb_pkg::ChanW-1:0] mem_b [stpb_pkg::TableDepth];
	logic [stpb_pkg::TableDepth-1:0] valid_q;

	logic [stpb_pkg::Lanes-1:0][stpb_pkg::ChanW-1:0]      data_q;
	logic [stpb_pkg::Lanes-1:0][stpb_pkg::TableAddrW-1:0] addr_q;
	logic [stpb_pkg::Lanes-1:0]                           hit_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_a[wr.addr] <= wr.data;
			mem_b[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			data_q[0] <= mem_a[rd_addr[0]];
			data_q[1] <= mem_a[rd_addr[1]];
			data_q[2] <= mem_b[rd_addr[2]];
			addr_q    <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_q   <= '0;
		end else begin
			if (rd_en) begin
				for (int i = 0; i < stpb_pkg::Lanes; i++) begin
					hit_q[i] <= valid_q[rd_addr[i]];
				end
			end
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
		end
	end

	// unwritten entries read as the identity ramp
	always_comb begin
		for (int i = 0; i < stpb_pkg::Lanes; i++) begin
			rd_data[i] = hit_q[i] ? data_q[i] : addr_q[i];
		end
	end

endmodule

### sv/stpb_blend_pipe.sv
// Blend datapath: alpha scaling, source-over mix per channel, coverage alpha,
// clamp and output register, with a per-stage ready chain. Uses stpb_pkg.
module stpb_blend_pipe (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  stpb_pkg::cfg_t                                  cfg,
	input  logic                                            pix_acc,
	input  logic [31:0]                                     dest_in,
	input  logic [stpb_pkg::Lanes-1:0][stpb_pkg::ChanW-1:0] cov,
	output logic                                            in_ready,
	output logic                                            out_valid,
	input  logic                                            out_ready,
	output logic [31:0]                                     new_pixel,
	output logic                                            written
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

	logic [31:0] dest_s1, dest_s2, dest_s3, dest_s4, dest_s5;
	logic [stpb_pkg::Lanes-1:0][15:0] prod_s2;
	logic [stpb_pkg::Lanes-1:0][7:0]  cs_s3;
	logic [stpb_pkg::Lanes-1:0][15:0] mix_s4;
	logic [7:0]                       ca_s4, ca_s5;
	logic                             zero_s4, zero_s5;
	logic [stpb_pkg::Lanes-1:0][7:0]  n_s5;
	logic [15:0]                      al_s5;
	logic [31:0]                      pixel_s6;
	logic                             written_s6;

	logic [stpb_pkg::Lanes-1:0][15:0] prod_d;
	logic [stpb_pkg::Lanes-1:0][7:0]  cs_d;
	logic [stpb_pkg::Lanes-1:0][15:0] mix_d;
	logic [stpb_pkg::Lanes-1:0][7:0]  n_d;
	logic [stpb_pkg::Lanes-1:0][7:0]  src;
	logic [stpb_pkg::Lanes-1:0][7:0]  dst;
	logic [9:0]                       sum_d;
	logic [15:0]                      al_d;
	logic [7:0]                       na_d;

	assign rdy6 = !v_s6 | out_ready;
	assign rdy5 = !v_s5 | rdy6;
	assign rdy4 = !v_s4 | rdy5;
	assign rdy3 = !v_s3 | rdy4;
	assign rdy2 = !v_s2 | rdy3;
	assign rdy1 = !v_s1 | rdy2;
	assign in_ready = rdy1;

	assign src[0] = cfg.red;
	assign src[1] = cfg.green;
	assign src[2] = cfg.blue;
	assign dst[0] = dest_s3[23:16];
	assign dst[1] = dest_s3[15:8];
	assign dst[2] = dest_s3[7:0];

	always_comb begin
		logic signed [17:0] diff;
		logic signed [17:0] term;
		logic        [17:0] base;
		logic        [17:0] acc;
		logic        [8:0]  quo;
		for (int i = 0; i < stpb_pkg::Lanes; i++) begin
			prod_d[i] = {8'd0, cov[i]} * {8'd0, cfg.alpha};
			quo       = stpb_pkg::div255(prod_s2[i]);
			cs_d[i]   = quo[7:0];
			// dst*255 + (src-dst)*cov + 127
			diff      = $signed({10'd0, src[i]}) - $signed({10'd0, dst[i]});
			term      = diff * $signed({10'd0, cs_s3[i]});
			base      = {2'd0, dst[i], 8'd0} - {10'd0, dst[i]};
			acc       = base + 18'(term) + 18'd127;
			mix_d[i]  = acc[15:0];
			n_d[i]    = stpb_pkg::clamp255(stpb_pkg::div255(mix_s4[i]));
		end
		sum_d = {2'd0, cs_s3[0]} + {2'd0, cs_s3[1]} + {2'd0, cs_s3[2]};
		al_d  = {8'd0, dest_s4[31:24]} * {8'd0, 8'hFF - ca_s4} + 16'd127;
		na_d  = stpb_pkg::clamp255({1'b0, ca_s5} + stpb_pkg::div255(al_s5));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= pix_acc;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
			if (rdy6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			dest_s1 <= dest_in;
		end
		if (rdy2) begin
			dest_s2 <= dest_s1;
			prod_s2 <= prod_d;
		end
		if (rdy3) begin
			dest_s3 <= dest_s2;
			cs_s3   <= cs_d;
		end
		if (rdy4) begin
			dest_s4 <= dest_s3;
			mix_s4  <= mix_d;
			ca_s4   <= stpb_pkg::div3(sum_d);
			zero_s4 <= (cs_s3 == '0);
		end
		if (rdy5) begin
			dest_s5 <= dest_s4;
			n_s5    <= n_d;
			al_s5   <= al_d;
			ca_s5   <= ca_s4;
			zero_s5 <= zero_s4;
		end
		if (rdy6) begin
			pixel_s6   <= zero_s5 ? dest_s5 : {na_d, n_s5[0], n_s5[1], n_s5[2]};
			written_s6 <= !zero_s5;
		end
	end

	assign out_valid = v_s6;
	assign new_pixel = pixel_s6;
	assign written   = written_s6;

endmodule

### sv/subpixel_text_pixel_blend.sv
// Subpixel text pixel blend: one beat per clock in while the output does not stall,
// one result beat per blend beat out from the registered blend pipeline; table-write beats
// return nothing. The rate is set by the gamma table: one copy read at two
// addresses and a second copy at the third, all three lanes in the same cycle.
// Table writes land at accept, so a following pixel beat always sees them; entries
// never written read as the identity ramp through per-entry valid bits, so there
// is no clearing pass after reset. Configure only while no pixel beat is in flight.
module subpixel_text_pixel_blend (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// cov_first, cov_middle, cov_last, dest_pixel, table_index, table_value
	input  logic [stpb_pkg::InDataW-1:0]      s_tdata,
	// kind
	input  logic [0:0]                        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// new_pixel
	output logic [stpb_pkg::OutDataW-1:0]     m_tdata,
	// written
	output logic [0:0]                        m_tuser,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [stpb_pkg::CfgAddrW-1:0]     paddr,
	input  logic [stpb_pkg::CfgDataW-1:0]     pwdata,
	output logic [stpb_pkg::CfgDataW-1:0]     prdata,
	output logic                              pready
);

	stpb_pkg::cfg_t    cfg;
	stpb_pkg::tbl_wr_t tbl_wr;
	stpb_pkg::kind_t   kind;
	logic              accept;
	logic              pix_acc;
	logic [7:0]        c0, c1, c2;
	logic [stpb_pkg::Lanes-1:0][stpb_pkg::TableAddrW-1:0] rd_addr;
	logic [stpb_pkg::Lanes-1:0][stpb_pkg::ChanW-1:0]      cov;
	logic              written;

	assign pready  = 1'b1;
	assign kind    = stpb_pkg::kind_t'(s_tuser[0]);
	assign accept  = s_tvalid & s_tready;
	assign pix_acc = accept & (kind == stpb_pkg::KIND_BLEND);
	assign c0      = s_tdata[7:0];
	assign c1      = s_tdata[15:8];
	assign c2      = s_tdata[23:16];

	assign tbl_wr.en   = accept & (kind == stpb_pkg::KIND_TABLE_WR);
	assign tbl_wr.addr = s_tdata[63:56];
	assign tbl_wr.data = s_tdata[71:64];

	always_comb begin
		if (cfg.mode) begin
			rd_addr[0] = cfg.bgr ? c2 : c0;
			rd_addr[1] = c1;
			rd_addr[2] = cfg.bgr ? c0 : c2;
		end else begin
			rd_addr[0] = c0;
			rd_addr[1] = c0;
			rd_addr[2] = c0;
		end
	end

	stpb_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	stpb_gamma_mem u_gamma (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (tbl_wr),
		.rd_en   (s_tready),
		.rd_addr (rd_addr),
		.rd_data (cov)
	);

	stpb_blend_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pix_acc   (pix_acc),
		.dest_in   (s_tdata[55:24]),
		.cov       (cov),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.new_pixel (m_tdata),
		.written   (written)
	);

	assign m_tuser[0] = written;

`ifndef SYNTHESIS
	a_empty_out_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with the output stage empty");

	a_reset_no_result: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("result beat presented during reset");

	a_table_wr_no_flow: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_wr.en |-> !pix_acc)
		else $error("table write and pixel accepted in the same beat");
`endif

endmodule

### test/tb_subpixel_text_pixel_blend.sv
`timescale 1ns / 1ps
// Testbench for subpixel_text_pixel_blend: a directed table, then random beats, checked
// beat by beat against a local blend predictor with its own gamma table and registers.
// Depends on stpb_pkg and the block RTL only.
module tb_subpixel_text_pixel_blend;
	import stpb_pkg::*;

	localparam int unsigned SETTLE_CYCLES   = 10;
	localparam int unsigned SEGMENTS        = 9;
	localparam int unsigned SEG_BEATS       = 90;
	localparam int unsigned HOLD_OFF_CYCLES = 120;
	localparam logic [2:0]  UNUSED_REG      = 3'd7;

	typedef struct packed {
		logic [31:0] pixel;
		logic        written;
	} pix_res_t;

	typedef enum logic {
		ROW_BEAT,
		ROW_REG
	} row_op_t;

	typedef struct packed {
		row_op_t     op;
		kind_t       kind;
		logic [7:0]  c0;
		logic [7:0]  c1;
		logic [7:0]  c2;
		logic [31:0] dst;
		logic [7:0]  tidx;
		logic [7:0]  tval;
		logic [2:0]  reg_idx;
		logic [31:0] reg_val;
		logic        typed;
		pix_res_t    want;
	} plan_row_t;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [InDataW-1:0]     s_tdata  = '0;
	logic [0:0]             s_tuser  = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OutDataW-1:0]    m_tdata;
	logic [0:0]             m_tuser;
	logic                   psel     = 1'b0;
	logic                   penable  = 1'b0;
	logic                   pwrite   = 1'b0;
	logic [CfgAddrW-1:0]    paddr    = '0;
	logic [CfgDataW-1:0]    pwdata   = '0;
	logic [CfgDataW-1:0]    prdata;
	logic                   pready;

	cfg_t        shadow_cfg;
	logic [7:0]  shadow_gamma [TableDepth];
	pix_res_t    pending_pixels [$];
	plan_row_t   plan [$];
	int unsigned mismatches  = 0;
	int unsigned tx_idle_pct = 34;
	int unsigned rx_idle_pct = 64;
	int unsigned hold_req    = 0;
	int unsigned hold_left   = 0;

	subpixel_text_pixel_blend dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hold off for a counted stretch when asked, else stall at random
	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin : result_check
		pix_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t: expected no beat, got new_pixel %h written %b",
					$time, m_tdata, m_tuser);
				mismatches++;
			end else begin
				want = pending_pixels.pop_front();
				if (m_tdata !== want.pixel) begin
					$display("%0t: new_pixel expected %h got %h", $time, want.pixel, m_tdata);
					mismatches++;
				end
				if (m_tuser[0] !== want.written) begin
					$display("%0t: written expected %b got %b", $time, want.written, m_tuser);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#(2_000_000);
		$display("CHECK FAILED");
		$finish;
	end

	function automatic void add_row(input plan_row_t r);
		plan.insert(plan.size(), r);
	endfunction

	function automatic void queue_pixel(input pix_res_t r);
		pending_pixels.insert(pending_pixels.size(), r);
	endfunction

	function automatic pix_res_t blend_pixel(input logic [7:0] c0, c1, c2,
		input logic [31:0] dst);
		int unsigned cov [3];
		int unsigned src [3];
		int unsigned dch [3];
		int unsigned mixed [3];
		int unsigned ca;
		int unsigned na;
		int unsigned da;
		pix_res_t r;
		if (shadow_cfg.mode) begin
			cov[0] = 32'(shadow_gamma[shadow_cfg.bgr ? c2 : c0]);
			cov[1] = 32'(shadow_gamma[c1]);
			cov[2] = 32'(shadow_gamma[shadow_cfg.bgr ? c0 : c2]);
		end else begin
			cov[0] = 32'(shadow_gamma[c0]);
			cov[1] = cov[0];
			cov[2] = cov[0];
		end
		src = '{32'(shadow_cfg.red), 32'(shadow_cfg.green), 32'(shadow_cfg.blue)};
		dch = '{32'(dst[23:16]), 32'(dst[15:8]), 32'(dst[7:0])};
		for (int i = 0; i < 3; i++)
			cov[i] = cov[i] * 32'(shadow_cfg.alpha) / 255;
		if ((cov[0] | cov[1] | cov[2]) == 0) begin
			r.pixel   = dst;
			r.written = 1'b0;
			return r;
		end
		for (int i = 0; i < 3; i++) begin
			mixed[i] = (src[i] * cov[i] + dch[i] * (255 - cov[i]) + 127) / 255;
			if (mixed[i] > 255)
				mixed[i] = 255;
		end
		da = 32'(dst[31:24]);
		ca = (cov[0] + cov[1] + cov[2]) / 3;
		na = ca + (da * (255 - ca) + 127) / 255;
		if (na > 255)
			na = 255;
		r.pixel   = {na[7:0], mixed[0][7:0], mixed[1][7:0], mixed[2][7:0]};
		r.written = 1'b1;
		return r;
	endfunction

	function automatic pix_res_t outcome(input logic [31:0] pixel, input logic written);
		pix_res_t r;
		r.pixel   = pixel;
		r.written = written;
		return r;
	endfunction

	function automatic plan_row_t beat_row(input kind_t kind, input logic [7:0] c0, c1, c2,
		input logic [31:0] dst, input logic [7:0] tidx, tval, input logic typed,
		input pix_res_t want);
		plan_row_t r;
		r = '0;
		r.op    = ROW_BEAT;
		r.kind  = kind;
		r.c0    = c0;
		r.c1    = c1;
		r.c2    = c2;
		r.dst   = dst;
		r.tidx  = tidx;
		r.tval  = tval;
		r.typed = typed;
		r.want  = want;
		return r;
	endfunction

	function automatic plan_row_t reg_row(input logic [2:0] idx, input logic [31:0] value);
		plan_row_t r;
		r = '0;
		r.op      = ROW_REG;
		r.reg_idx = idx;
		r.reg_val = value;
		return r;
	endfunction

	function automatic logic [7:0] pick_level();
		case ($urandom_range(5))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_cov();
		case ($urandom_range(9))
			0, 1: return 8'h00;
			2: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic send_beat(input kind_t kind, input logic [7:0] c0, c1, c2,
		input logic [31:0] dst, input logic [7:0] tidx, tval, input logic typed,
		input pix_res_t want);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= 1'(kind);
		s_tdata  <= {tval, tidx, dst, c2, c1, c0};
		do @(posedge clk); while (!s_tready);
		if (kind == KIND_TABLE_WR)
			shadow_gamma[tidx] = tval;
		else
			queue_pixel(typed ? want : blend_pixel(c0, c1, c2, dst));
	endtask

	// drop valid and wait for every pending result; optionally let the pipe empty too
	task automatic settle(input logic extra);
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_pixels.size() != 0);
		if (extra)
			repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		logic [31:0] want;
		logic        known;
		known = 1'b1;
		want  = '0;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_TEXT_RED:      begin shadow_cfg.red   = value[7:0]; want = {24'd0, value[7:0]}; end
			REG_TEXT_GREEN:    begin shadow_cfg.green = value[7:0]; want = {24'd0, value[7:0]}; end
			REG_TEXT_BLUE:     begin shadow_cfg.blue  = value[7:0]; want = {24'd0, value[7:0]}; end
			REG_TEXT_ALPHA:    begin shadow_cfg.alpha = value[7:0]; want = {24'd0, value[7:0]}; end
			REG_BGR_ORDER:     begin shadow_cfg.bgr   = value[0];   want = {31'd0, value[0]};   end
			REG_SUBPIXEL_MODE: begin shadow_cfg.mode  = value[0];   want = {31'd0, value[0]};   end
			default: known = 1'b0;
		endcase
		if (known) begin
			penable <= 1'b0;
			pwrite  <= 1'b0;
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
			if (prdata !== want) begin
				$display("%0t: register %0d readback expected %h got %h",
					$time, idx, want, prdata);
				mismatches++;
			end
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		pix_res_t   none;
		kind_t      k;
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] c;

		shadow_cfg.red   = 8'h00;
		shadow_cfg.green = 8'h00;
		shadow_cfg.blue  = 8'h00;
		shadow_cfg.alpha = 8'hFF;
		shadow_cfg.bgr   = 1'b0;
		shadow_cfg.mode  = 1'b0;
		for (int i = 0; i < TableDepth; i++)
			shadow_gamma[i] = 8'(i);
		none = outcome(32'h0, 1'b0);

		add_row(beat_row(KIND_BLEND, 8'h00, 8'h00, 8'h00, 32'h12345678, 8'h00, 8'h00,
			1'b1, outcome(32'h12345678, 1'b0)));
		add_row(beat_row(KIND_BLEND, 8'hFF, 8'h00, 8'h00, 32'hFFFFFFFF, 8'hFF, 8'hFF,
			1'b1, outcome(32'hFF000000, 1'b1)));
		add_row(beat_row(KIND_BLEND, 8'hFF, 8'hFF, 8'hFF, 32'h00000000, 8'h00, 8'h00,
			1'b1, outcome(32'hFF000000, 1'b1)));
		add_row(beat_row(KIND_BLEND, 8'h00, 8'hFF, 8'hFF, 32'hFFFFFFFF, 8'h00, 8'h00,
			1'b1, outcome(32'hFFFFFFFF, 1'b0)));
		add_row(beat_row(KIND_BLEND, 8'h01, 8'h80, 8'h7F, 32'h80402010, 8'h00, 8'h00,
			1'b0, none));
		add_row(beat_row(KIND_TABLE_WR, 8'hFF, 8'hFF, 8'hFF, 32'hFFFFFFFF, 8'h00, 8'hFF,
			1'b0, none));
		add_row(beat_row(KIND_BLEND, 8'h00, 8'h00, 8'h00, 32'h00000000, 8'h00, 8'h00,
			1'b0, none));
		add_row(beat_row(KIND_TABLE_WR, 8'h00, 8'h00, 8'h00, 32'h00000000, 8'hFF, 8'h00,
			1'b0, none));
		add_row(beat_row(KIND_BLEND, 8'hFF, 8'hFF, 8'hFF, 32'hAABBCCDD, 8'h00, 8'h00,
			1'b1, outcome(32'hAABBCCDD, 1'b0)));
		add_row(beat_row(KIND_TABLE_WR, 8'h00, 8'h00, 8'h00, 32'h00000000, 8'h00, 8'h00,
			1'b0, none));
		add_row(beat_row(KIND_TABLE_WR, 8'h00, 8'h00, 8'h00, 32'h00000000, 8'hFF, 8'hFF,
			1'b0, none));
		add_row(reg_row(REG_TEXT_RED, 32'hFFFFFFFF));
		add_row(reg_row(REG_TEXT_GREEN, 32'h00000080));
		add_row(reg_row(REG_TEXT_BLUE, 32'h00000001));
		add_row(reg_row(REG_SUBPIXEL_MODE, 32'h00000001));
		add_row(beat_row(KIND_BLEND, 8'hFF, 8'h80, 8'h00, 32'h00000000, 8'h00, 8'h00,
			1'b0, none));
		add_row(beat_row(KIND_BLEND, 8'h00, 8'h00, 8'h00, 32'hFFFFFFFF, 8'h00, 8'h00,
			1'b1, outcome(32'hFFFFFFFF, 1'b0)));
		add_row(beat_row(KIND_BLEND, 8'h0A, 8'hC8, 8'h4D, 32'h7F3F1F0F, 8'h00, 8'h00,
			1'b0, none));
		add_row(reg_row(REG_BGR_ORDER, 32'h00000001));
		add_row(beat_row(KIND_BLEND, 8'hFF, 8'h00, 8'h00, 32'h00000000, 8'h00, 8'h00,
			1'b0, none));
		add_row(beat_row(KIND_BLEND, 8'h0A, 8'hC8, 8'h4D, 32'h7F3F1F0F, 8'h00, 8'h00,
			1'b0, none));
		add_row(reg_row(REG_TEXT_ALPHA, 32'h00000000));
		add_row(beat_row(KIND_BLEND, 8'hFF, 8'hFF, 8'hFF, 32'h5A5A5A5A, 8'h00, 8'h00,
			1'b1, outcome(32'h5A5A5A5A, 1'b0)));
		add_row(reg_row(REG_TEXT_ALPHA, 32'h00000001));
		add_row(beat_row(KIND_BLEND, 8'hFF, 8'hFF, 8'hFF, 32'hFFFFFFFF, 8'h00, 8'h00,
			1'b0, none));
		add_row(beat_row(KIND_BLEND, 8'hFE, 8'hFE, 8'hFE, 32'h01020304, 8'h00, 8'h00,
			1'b1, outcome(32'h01020304, 1'b0)));
		add_row(reg_row(UNUSED_REG, 32'hFFFFFFFF));
		add_row(beat_row(KIND_BLEND, 8'h80, 8'h40, 8'h20, 32'hC0C0C0C0, 8'h00, 8'h00,
			1'b0, none));
		add_row(reg_row(REG_TEXT_ALPHA, 32'h000000C8));
		add_row(reg_row(REG_SUBPIXEL_MODE, 32'hFFFFFFFE));
		add_row(reg_row(REG_BGR_ORDER, 32'h00000000));
		add_row(beat_row(KIND_BLEND, 8'hC8, 8'h01, 8'h02, 32'h33445566, 8'h00, 8'h00,
			1'b0, none));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].op == ROW_REG) begin
				settle(1'b1);
				write_reg(plan[i].reg_idx, plan[i].reg_val);
			end else begin
				send_beat(plan[i].kind, plan[i].c0, plan[i].c1, plan[i].c2, plan[i].dst,
					plan[i].tidx, plan[i].tval, plan[i].typed, plan[i].want);
			end
		end

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			tx_idle_pct = (seg < 3) ? 34 : (seg < 6) ? 64 : 0;
			rx_idle_pct = (seg < 3) ? 64 : (seg < 6) ? 34 : 0;
			settle(1'b1);
			write_reg(REG_TEXT_RED,      {24'($urandom), pick_level()});
			write_reg(REG_TEXT_GREEN,    {24'($urandom), pick_level()});
			write_reg(REG_TEXT_BLUE,     {24'($urandom), pick_level()});
			write_reg(REG_TEXT_ALPHA,    {24'($urandom), pick_level()});
			write_reg(REG_BGR_ORDER,     {31'($urandom), 1'(seg >> 1)});
			write_reg(REG_SUBPIXEL_MODE, {31'($urandom), 1'(seg)});
			if ($urandom_range(1) == 0)
				write_reg(UNUSED_REG, $urandom);
			for (int n = 0; n < SEG_BEATS; n++) begin
				if (seg == 1 && n == 30)
					hold_req = HOLD_OFF_CYCLES;
				if (seg == 4 && n == 45)
					settle(1'b0);
				k = ($urandom_range(99) < 12) ? KIND_TABLE_WR : KIND_BLEND;
				a = pick_cov();
				b = pick_cov();
				c = pick_cov();
				if ($urandom_range(9) == 0) begin
					a = 8'h00;
					b = 8'h00;
					c = 8'h00;
				end
				send_beat(k, a, b, c, $urandom, 8'($urandom), 8'($urandom), 1'b0, none);
			end
		end

		settle(1'b1);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
